### sv/srs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_pkg
// Shared types and codes for the sorted record stack: item kinds, result
// status codes, the record layout and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package srs_pkg;

  localparam int KeyW = 16;
  localparam int ValW = 16;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_MODIFY = 2'd1;
  localparam logic [1:0] KIND_DUMP   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [ValW-1:0] height;
    logic [ValW-1:0] weight;
  } rec_t;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_INSERT,
    OP_MODIFY,
    OP_ROTATE
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       emit;
    logic       emit_data;
    logic [1:0] status;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic found;
  } stat_t;

endpackage

### sv/srs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_datapath
// Chain of record cells kept in descending key order, the record count and
// the result registers. Each cell decides its own next value from its
// neighbors, so an insert, a modify or one dump step updates every cell at once.
// ----------------------------------------------------------------------------
module srs_datapath #(
  parameter int DEPTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  srs_pkg::cmd_t               cmd_i,
  input  logic [srs_pkg::KeyW-1:0]    roll_key_i,
  input  logic [srs_pkg::ValW-1:0]    height_in_i,
  input  logic [srs_pkg::ValW-1:0]    weight_in_i,
  output srs_pkg::stat_t              stat_o,
  output logic [$clog2(DEPTH+1)-1:0]  count_o,
  output logic                        valid_o,
  output logic [1:0]                  status_o,
  output logic [srs_pkg::KeyW-1:0]    key_out_o,
  output logic [srs_pkg::ValW-1:0]    height_out_o,
  output logic [srs_pkg::ValW-1:0]    weight_out_o,
  output logic                        last_o
);

  localparam int CW = $clog2(DEPTH+1);

  srs_pkg::rec_t rec_q [DEPTH];
  srs_pkg::rec_t rec_d [DEPTH];
  srs_pkg::rec_t new_rec;
  srs_pkg::rec_t out_d;
  srs_pkg::rec_t out_q;

  logic [CW-1:0]    count_q, count_d;
  logic [DEPTH-1:0] gt, eq, hit, at_pos, is_bottom;
  logic             valid_q, last_q;
  logic [1:0]       status_q;

  assign new_rec = '{key: roll_key_i, height: height_in_i, weight: weight_in_i};

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam logic [CW-1:0] Idx = CW'(g);
    logic in_use;

    assign in_use       = Idx < count_q;
    assign gt[g]        = in_use && (rec_q[g].key > roll_key_i);
    assign eq[g]        = in_use && (rec_q[g].key == roll_key_i);
    assign is_bottom[g] = Idx == (count_q - CW'(1));

    // Keys are sorted, so equal keys sit together: the topmost match is the
    // one whose upper neighbor does not match. Likewise the insert slot is
    // the first cell whose key is not greater than the new one.
    if (g == 0) begin : g_top
      assign hit[g]    = eq[g];
      assign at_pos[g] = !gt[g];
    end else begin : g_inner
      assign hit[g]    = eq[g] && !eq[g-1];
      assign at_pos[g] = !gt[g] && gt[g-1];
    end

    srs_pkg::rec_t from_above;
    srs_pkg::rec_t from_below;
    if (g == 0) begin : g_above0
      assign from_above = new_rec;
    end else begin : g_above
      assign from_above = rec_q[g-1];
    end
    if (g == DEPTH-1) begin : g_belowl
      assign from_below = rec_q[0];
    end else begin : g_below
      assign from_below = rec_q[g+1];
    end

    always_comb begin
      rec_d[g] = rec_q[g];
      unique case (cmd_i.op)
        srs_pkg::OP_INSERT: begin
          if (at_pos[g]) begin
            rec_d[g] = new_rec;
          end else if (!gt[g]) begin
            rec_d[g] = from_above;
          end
        end
        srs_pkg::OP_MODIFY: begin
          if (hit[g]) begin
            rec_d[g].weight = weight_in_i;
          end
        end
        srs_pkg::OP_ROTATE: begin
          // Rotate the occupied part up by one; the top goes to the bottom.
          rec_d[g] = is_bottom[g] ? rec_q[0] : from_below;
        end
        default: begin
          rec_d[g] = rec_q[g];
        end
      endcase
    end

    always_ff @(posedge clk_i) begin
      rec_q[g] <= rec_d[g];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.op == srs_pkg::OP_INSERT) begin
      count_d = count_q + CW'(1);
    end
  end

  assign out_d = cmd_i.emit_data ? rec_q[0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      valid_q  <= 1'b0;
      status_q <= srs_pkg::ST_OK;
      last_q   <= 1'b0;
    end else begin
      count_q  <= count_d;
      valid_q  <= cmd_i.emit;
      status_q <= cmd_i.status;
      last_q   <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign stat_o.full  = count_q == CW'(DEPTH);
  assign stat_o.empty = count_q == '0;
  assign stat_o.found = |eq;
  assign count_o      = count_q;

  assign valid_o      = valid_q;
  assign status_o     = status_q;
  assign last_o       = last_q;
  assign key_out_o    = out_q.key;
  assign height_out_o = out_q.height;
  assign weight_out_o = out_q.weight;

endmodule

### sv/srs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_ctrl
// Controller for the sorted record stack. Decodes each accepted item into a
// datapath command and sequences a dump one record per cycle.
// ----------------------------------------------------------------------------
module srs_ctrl #(
  parameter int DEPTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [1:0]                  kind_i,
  input  srs_pkg::stat_t              stat_i,
  input  logic [$clog2(DEPTH+1)-1:0]  count_i,
  output srs_pkg::cmd_t               cmd_o,
  output logic                        busy_o
);

  localparam int CW = $clog2(DEPTH+1);

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] rem_q, rem_d;
  logic          busy_q, busy_d;

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    cmd_o   = '{op: srs_pkg::OP_NOP, emit: 1'b0, emit_data: 1'b0,
                status: srs_pkg::ST_OK, last: 1'b0};
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (kind_i)
            srs_pkg::KIND_INSERT: begin
              cmd_o.emit = 1'b1;
              cmd_o.last = 1'b1;
              if (stat_i.full) begin
                cmd_o.status = srs_pkg::ST_FULL;
              end else begin
                cmd_o.op = srs_pkg::OP_INSERT;
              end
            end
            srs_pkg::KIND_MODIFY: begin
              cmd_o.emit = 1'b1;
              cmd_o.last = 1'b1;
              if (stat_i.found) begin
                cmd_o.op = srs_pkg::OP_MODIFY;
              end else begin
                cmd_o.status = srs_pkg::ST_NOT_FOUND;
              end
            end
            srs_pkg::KIND_DUMP: begin
              if (stat_i.empty) begin
                cmd_o.emit   = 1'b1;
                cmd_o.last   = 1'b1;
                cmd_o.status = srs_pkg::ST_EMPTY;
              end else begin
                state_d = S_DUMP;
                rem_d   = count_i;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_DUMP: begin
        // Emit the top record and rotate it to the bottom; after count
        // steps the table is back in its original order.
        cmd_o.op        = srs_pkg::OP_ROTATE;
        cmd_o.emit      = 1'b1;
        cmd_o.emit_data = 1'b1;
        cmd_o.last      = rem_q == CW'(1);
        rem_d           = rem_q - CW'(1);
        if (cmd_o.last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    busy_d = state_d == S_DUMP;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rem_q   <= '0;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
      busy_q  <= busy_d;
    end
  end

  assign busy_o = busy_q;

endmodule

### sv/sorted_record_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_record_stack
// Insert and modify give their result in the cycle after acceptance, and a
// new item can be accepted every cycle while busy_o is low. A dump of n
// records enters S_DUMP, then the result registers give one record per
// cycle; busy_o stays high during S_DUMP (one rotation step per record).
// Reset clears the record count; record contents are not cleared.
// Results are strobed by valid_o for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module sorted_record_stack #(
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [1:0]               kind_i,
  input  logic [srs_pkg::KeyW-1:0] roll_key_i,
  input  logic [srs_pkg::ValW-1:0] height_in_i,
  input  logic [srs_pkg::ValW-1:0] weight_in_i,
  output logic                     valid_o,
  output logic [1:0]               status_o,
  output logic [srs_pkg::KeyW-1:0] key_out_o,
  output logic [srs_pkg::ValW-1:0] height_out_o,
  output logic [srs_pkg::ValW-1:0] weight_out_o,
  output logic                     last_o
);

  localparam int CW = $clog2(DEPTH+1);

  srs_pkg::cmd_t  cmd;
  srs_pkg::stat_t stat;
  logic [CW-1:0]  count;

  srs_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .kind_i  (kind_i),
    .stat_i  (stat),
    .count_i (count),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  srs_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .roll_key_i   (roll_key_i),
    .height_in_i  (height_in_i),
    .weight_in_i  (weight_in_i),
    .stat_o       (stat),
    .count_o      (count),
    .valid_o      (valid_o),
    .status_o     (status_o),
    .key_out_o    (key_out_o),
    .height_out_o (height_out_o),
    .weight_out_o (weight_out_o),
    .last_o       (last_o)
  );

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_record_stack. A clocked driver presents
// insert, modify, dump and ignored items from a queue filled up front. A
// shadow copy of the record table predicts every result. A clocked monitor
// compares each strobed result, field by field, against the oldest
// prediction. The run starts with a short directed part and then moves
// through random phases with different amounts of sender idling.
// ----------------------------------------------------------------------------
module tb;

  localparam int Depth = 32;
  localparam int RandomItems = 400;
  localparam int CycleLimit = 300000;
  localparam int MaxReports = 40;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]               kind;
    logic [srs_pkg::KeyW-1:0] key;
    logic [srs_pkg::ValW-1:0] height;
    logic [srs_pkg::ValW-1:0] weight;
    bit                       hold;      // present only once every result is back
    int                       idle_pct;  // chance per cycle that the sender stays idle
  } item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [srs_pkg::KeyW-1:0] key;
    logic [srs_pkg::ValW-1:0] height;
    logic [srs_pkg::ValW-1:0] weight;
    logic                     last;
  } result_t;

  logic                     clk_i = 1'b1;
  logic                     rst_ni = 1'b0;
  logic                     start_i = 1'b0;
  logic [1:0]               kind_i = srs_pkg::KIND_INSERT;
  logic [srs_pkg::KeyW-1:0] roll_key_i = '0;
  logic [srs_pkg::ValW-1:0] height_in_i = '0;
  logic [srs_pkg::ValW-1:0] weight_in_i = '0;
  logic                     busy_o;
  logic                     valid_o;
  logic [1:0]               status_o;
  logic [srs_pkg::KeyW-1:0] key_out_o;
  logic [srs_pkg::ValW-1:0] height_out_o;
  logic [srs_pkg::ValW-1:0] weight_out_o;
  logic                     last_o;

  item_t   item_queue[$];
  result_t expected_results[$];

  // Shadow of the record table, entry 0 on top.
  srs_pkg::rec_t shadow_recs[Depth];
  int            shadow_count = 0;

  // Generator-side bookkeeping, used to aim modifies at stored keys.
  logic [srs_pkg::KeyW-1:0] gen_keys[$];
  int                       gen_count = 0;

  int errors = 0;
  int checked = 0;
  int cycle_count = 0;
  int n_inserts = 0;
  int n_modifies = 0;
  int n_dumps = 0;
  int n_ignored = 0;
  int n_full = 0;
  int n_not_found = 0;
  int n_empty = 0;

  sorted_record_stack #(
    .DEPTH(Depth)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .kind_i      (kind_i),
    .roll_key_i  (roll_key_i),
    .height_in_i (height_in_i),
    .weight_in_i (weight_in_i),
    .valid_o     (valid_o),
    .status_o    (status_o),
    .key_out_o   (key_out_o),
    .height_out_o(height_out_o),
    .weight_out_o(weight_out_o),
    .last_o      (last_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Works out the results of one accepted item and updates the shadow table.
  function automatic void predict_records(logic [1:0] kind,
                                          logic [srs_pkg::KeyW-1:0] key,
                                          logic [srs_pkg::ValW-1:0] height,
                                          logic [srs_pkg::ValW-1:0] weight);
    int      pos;
    int      i;
    bit      hit;
    result_t res;
    res = '0;
    res.last = 1'b1;
    case (kind)
      srs_pkg::KIND_INSERT: begin
        n_inserts++;
        if (shadow_count >= Depth) begin
          res.status = srs_pkg::ST_FULL;
          n_full++;
        end else begin
          pos = 0;
          while (pos < shadow_count && shadow_recs[pos].key > key) pos++;
          for (i = shadow_count; i > pos; i--) shadow_recs[i] = shadow_recs[i-1];
          shadow_recs[pos] = '{key, height, weight};
          shadow_count++;
          res.status = srs_pkg::ST_OK;
        end
        expected_results.push_back(res);
      end
      srs_pkg::KIND_MODIFY: begin
        n_modifies++;
        hit = 1'b0;
        for (i = 0; i < shadow_count && !hit; i++) begin
          if (shadow_recs[i].key == key) begin
            shadow_recs[i].weight = weight;
            hit = 1'b1;
          end
        end
        res.status = hit ? srs_pkg::ST_OK : srs_pkg::ST_NOT_FOUND;
        if (!hit) n_not_found++;
        expected_results.push_back(res);
      end
      srs_pkg::KIND_DUMP: begin
        n_dumps++;
        if (shadow_count == 0) begin
          res.status = srs_pkg::ST_EMPTY;
          n_empty++;
          expected_results.push_back(res);
        end else begin
          for (i = 0; i < shadow_count; i++) begin
            res.status = srs_pkg::ST_OK;
            res.key = shadow_recs[i].key;
            res.height = shadow_recs[i].height;
            res.weight = shadow_recs[i].weight;
            res.last = (i == shadow_count - 1);
            expected_results.push_back(res);
          end
        end
      end
      default: n_ignored++;
    endcase
  endfunction

  function automatic void queue_item(logic [1:0] kind, logic [srs_pkg::KeyW-1:0] key,
                                     logic [srs_pkg::ValW-1:0] height,
                                     logic [srs_pkg::ValW-1:0] weight,
                                     bit hold, int idle_pct);
    item_t it;
    it = '{kind, key, height, weight, hold, idle_pct};
    item_queue.push_back(it);
    if (kind == srs_pkg::KIND_INSERT && gen_count < Depth) begin
      gen_keys.push_back(key);
      gen_count++;
    end
  endfunction

  function automatic logic [srs_pkg::KeyW-1:0] corner_key();
    case ($urandom_range(6))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'h7FFF;
      3: return 16'h8000;
      4: return 16'hFFFE;
      5: return 16'hFFFF;
      default: return 16'h0002;
    endcase
  endfunction

  function automatic logic [srs_pkg::KeyW-1:0] stored_key();
    if (gen_keys.size() == 0) return 16'($urandom);
    return gen_keys[$urandom_range(gen_keys.size() - 1)];
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      if (errors <= MaxReports)
        $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endfunction

  // Driver: the item on the ports is taken at an edge with start high and
  // busy low; while busy it is held, otherwise the next one may follow.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        predict_records(kind_i, roll_key_i, height_in_i, weight_in_i);
        void'(item_queue.pop_front());
      end
      if (start_i && busy_o) begin
        start_i <= 1'b1;
      end else if (item_queue.size() != 0 &&
                   !(item_queue[0].hold && expected_results.size() != 0) &&
                   $urandom_range(99) >= item_queue[0].idle_pct) begin
        start_i <= 1'b1;
        kind_i <= item_queue[0].kind;
        roll_key_i <= item_queue[0].key;
        height_in_i <= item_queue[0].height;
        weight_in_i <= item_queue[0].weight;
      end else begin
        // Garbage on the data ports while idle must be ignored.
        start_i <= 1'b0;
        kind_i <= 2'($urandom);
        roll_key_i <= 16'($urandom);
        height_in_i <= 16'($urandom);
        weight_in_i <= 16'($urandom);
      end
    end
  end

  // Monitor: every strobed result is matched against the oldest prediction.
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && valid_o) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t ns: unexpected result, expected none actual %h %h %h %h %b",
                   $time, status_o, key_out_o, height_out_o, weight_out_o, last_o);
      end else begin
        want = expected_results.pop_front();
        checked++;
        check_field("status", int'(want.status), int'(status_o));
        check_field("key_out", int'(want.key), int'(key_out_o));
        check_field("height_out", int'(want.height), int'(height_out_o));
        check_field("weight_out", int'(want.weight), int'(weight_out_o));
        check_field("last", int'(want.last), int'(last_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Cycle limit reached with %0d items and %0d results outstanding.",
               item_queue.size(), expected_results.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    int phase_idle[4];
    int phase;
    int counted;
    int pick;
    bit hold;
    logic [1:0] kind;
    logic [srs_pkg::KeyW-1:0] key;
    phase_idle = '{0, 82, 6, 0};

    // Directed part: empty-table cases, field extremes, equal keys, and an
    // ignored kind.
    queue_item(srs_pkg::KIND_DUMP, 16'h0000, 16'h0000, 16'h0000, 1'b0, 0);
    queue_item(srs_pkg::KIND_MODIFY, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0, 0);
    queue_item(srs_pkg::KIND_INSERT, 16'h8000, 16'h0000, 16'h0000, 1'b0, 0);
    queue_item(srs_pkg::KIND_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 0);
    queue_item(srs_pkg::KIND_INSERT, 16'h0000, 16'h1234, 16'h5678, 1'b0, 0);
    queue_item(srs_pkg::KIND_INSERT, 16'hFFFF, 16'h0001, 16'h0002, 1'b0, 0);
    queue_item(srs_pkg::KIND_INSERT, 16'h8000, 16'hAAAA, 16'h5555, 1'b0, 0);
    queue_item(srs_pkg::KIND_DUMP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 0);
    queue_item(srs_pkg::KIND_MODIFY, 16'hFFFF, 16'h0000, 16'hBEEF, 1'b0, 0);
    queue_item(srs_pkg::KIND_MODIFY, 16'h0000, 16'h0000, 16'h0000, 1'b0, 0);
    queue_item(srs_pkg::KIND_MODIFY, 16'h1234, 16'h0000, 16'hFFFF, 1'b0, 0);
    queue_item(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 0);
    queue_item(srs_pkg::KIND_INSERT, 16'h7FFF, 16'h5555, 16'hAAAA, 1'b0, 0);
    queue_item(srs_pkg::KIND_DUMP, 16'h0000, 16'h0000, 16'h0000, 1'b1, 0);
    queue_item(srs_pkg::KIND_INSERT, 16'h0001, 16'h8000, 16'h7FFF, 1'b0, 0);
    queue_item(srs_pkg::KIND_DUMP, 16'h0000, 16'h0000, 16'h0000, 1'b0, 0);

    // Random part: the table fills with many duplicate keys, then keeps
    // taking modifies, dumps and refused inserts.
    counted = 0;
    phase = 0;
    while (counted < RandomItems) begin
      hold = (counted % (RandomItems / 4) == 0) || ($urandom_range(99) < 2);
      phase = counted / (RandomItems / 4);
      pick = $urandom_range(99);
      if (pick < 4) kind = KIND_UNUSED;
      else if (gen_count < Depth) kind = (pick < 60) ? srs_pkg::KIND_INSERT :
                                         (pick < 85) ? srs_pkg::KIND_MODIFY :
                                                       srs_pkg::KIND_DUMP;
      else kind = (pick < 16) ? srs_pkg::KIND_INSERT :
                  (pick < 64) ? srs_pkg::KIND_MODIFY : srs_pkg::KIND_DUMP;
      pick = $urandom_range(99);
      if (kind == srs_pkg::KIND_MODIFY) key = (pick < 75) ? stored_key() : 16'($urandom);
      else if (pick < 30) key = corner_key();
      else if (pick < 50) key = stored_key();
      else key = 16'($urandom);
      queue_item(kind, key, 16'($urandom), 16'($urandom), hold, phase_idle[phase]);
      if (kind != KIND_UNUSED) counted++;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (item_queue.size() != 0 || start_i) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Covered %0d inserts (%0d refused on a full table), %0d modifies (%0d misses),",
             n_inserts, n_full, n_modifies, n_not_found);
    $display("%0d dumps (%0d on an empty table), %0d ignored items; %0d results checked.",
             n_dumps, n_empty, n_ignored, checked);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
